// File: rtl/asmf_pkg.sv
// Shared types and constants for the alignment score matrix fill unit.
`timescale 1ns / 1ps

package asmf_pkg;

    localparam int MAX_COLS_DEF   = 1024;
    localparam int SCORE_BITS_DEF = 24;
    localparam int PEN_W          = 16;
    localparam int SUB_W          = 16;
    localparam int COLS_CFG_W     = 11;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 11'd1024;

    typedef enum logic [1:0] {
        DIR_DIAG  = 2'd0,
        DIR_NORTH = 2'd1,
        DIR_WEST  = 2'd2
    } dir_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAP_OPEN    = 2'd0,
        REG_GAP_EXTEND  = 2'd1,
        REG_GLOBAL_MODE = 2'd2,
        REG_COLS_IN_USE = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [PEN_W-1:0]      gap_open;
        logic [PEN_W-1:0]      gap_extend;
        logic                  global_mode;
        logic [COLS_CFG_W-1:0] cols_in_use;
    } cfg_t;

endpackage

// File: rtl/asmf_line_store.sv
// Previous-row line store: one write port, one registered read port with write bypass.
`timescale 1ns / 1ps

module asmf_line_store
    import asmf_pkg::*;
#(
    parameter int DEPTH = MAX_COLS_DEF,
    parameter int WIDTH = SCORE_BITS_DEF + 2
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // A read of the entry being written in the same cycle returns the new data.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/asmf_cell_pe.sv
// Cell processing element: row state registers and the score recurrence for one cell.
`timescale 1ns / 1ps

module asmf_cell_pe
    import asmf_pkg::*;
#(
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int SCORE_BITS = SCORE_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  cfg_t                                cfg,
    input  logic                                fire,
    input  logic                                restart,
    input  logic signed [SUB_W-1:0]             sub_score,
    input  logic signed [SCORE_BITS-1:0]        up_score_mem,
    input  dir_t                                up_dir_mem,
    input  logic signed [SCORE_BITS-1:0]        border_pre,
    output logic signed [SCORE_BITS-1:0]        best,
    output dir_t                                dec,
    output logic                                last,
    output logic [$clog2(MAX_COLS)-1:0]         col,
    output logic [$clog2(MAX_COLS)-1:0]         col_after
);

    localparam int SW    = SCORE_BITS;
    localparam int EW    = SCORE_BITS + 2;
    localparam int IDX_W = $clog2(MAX_COLS);
    localparam int CNT_W = $clog2(MAX_COLS + 1);
    localparam int NW    = (CNT_W > COLS_CFG_W) ? CNT_W : COLS_CFG_W;

    logic [IDX_W-1:0]     col_reg, col_next;
    logic                 first_row_reg, first_row_next;
    logic signed [SW-1:0] diag_reg, diag_next;
    logic signed [SW-1:0] left_reg, left_next;
    dir_t                 ldir_reg, ldir_next;
    logic signed [SW-1:0] row_border_reg, row_border_next;

    logic [NW-1:0]        ncols;
    logic                 first_row;
    logic signed [SW-1:0] diag, left, rb, rb_step, up, n_cand, d_cand, w_cand, floor_v;
    dir_t                 ldir, up_dir;
    logic signed [EW-1:0] ext_e, opn_e;

    function automatic logic signed [SW-1:0] sat_f(input logic signed [EW-1:0] v);
        logic signed [SW-1:0] r;
        if ((v[EW-1:SW-1] == '0) || (v[EW-1:SW-1] == '1))
        begin
            r = v[SW-1:0];
        end
        else if (v[EW-1])
        begin
            r = {1'b1, {(SW-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(SW-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [EW-1:0] ext_f(input logic signed [SW-1:0] v);
        return {{(EW-SW){v[SW-1]}}, v};
    endfunction

    always_comb
    begin
        ext_e = signed'({{(EW-PEN_W){1'b0}}, cfg.gap_extend});
        opn_e = signed'({{(EW-PEN_W){1'b0}}, cfg.gap_open});

        if (cfg.cols_in_use == '0)
        begin
            ncols = NW'(1);
        end
        else if (NW'(cfg.cols_in_use) > NW'(MAX_COLS))
        begin
            ncols = NW'(MAX_COLS);
        end
        else
        begin
            ncols = NW'(cfg.cols_in_use);
        end

        if (restart)
        begin
            col       = '0;
            first_row = 1'b1;
            diag      = '0;
            rb        = cfg.global_mode ? sat_f(-ext_e) : '0;
            left      = rb;
            ldir      = DIR_DIAG;
        end
        else
        begin
            col       = col_reg;
            first_row = first_row_reg;
            diag      = diag_reg;
            rb        = row_border_reg;
            left      = left_reg;
            ldir      = ldir_reg;
        end

        last = ((NW'(col) + NW'(1)) >= ncols);

        if (first_row)
        begin
            up     = cfg.global_mode ? border_pre : '0;
            up_dir = DIR_DIAG;
        end
        else
        begin
            up     = up_score_mem;
            up_dir = up_dir_mem;
        end

        n_cand = sat_f(ext_f(up) - ((up_dir == DIR_NORTH) ? ext_e : opn_e));
        d_cand = sat_f(ext_f(diag) + {{(EW-SUB_W){sub_score[SUB_W-1]}}, sub_score});
        w_cand = sat_f(ext_f(left) - ((ldir == DIR_WEST) ? ext_e : opn_e));

        floor_v = '0;
        if (cfg.global_mode)
        begin
            if (left < floor_v)
            begin
                floor_v = left;
            end
            if (diag < floor_v)
            begin
                floor_v = diag;
            end
            if (up < floor_v)
            begin
                floor_v = up;
            end
        end

        // North, then diagonal, then west; a later candidate wins only when strictly greater.
        best = floor_v;
        dec  = DIR_DIAG;
        if (n_cand > best)
        begin
            best = n_cand;
            dec  = DIR_NORTH;
        end
        if (d_cand > best)
        begin
            best = d_cand;
            dec  = DIR_DIAG;
        end
        if (w_cand > best)
        begin
            best = w_cand;
            dec  = DIR_WEST;
        end

        rb_step = cfg.global_mode ? sat_f(ext_f(rb) - ext_e) : '0;

        if (last)
        begin
            diag_next       = rb;
            row_border_next = rb_step;
            left_next       = rb_step;
            ldir_next       = DIR_DIAG;
            col_next        = '0;
            first_row_next  = 1'b0;
        end
        else
        begin
            diag_next       = up;
            row_border_next = rb;
            left_next       = best;
            ldir_next       = dec;
            col_next        = col + IDX_W'(1);
            first_row_next  = first_row;
        end

        col_after = fire ? col_next : col_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            first_row_reg  <= 1'b1;
            diag_reg       <= '0;
            left_reg       <= '0;
            ldir_reg       <= DIR_DIAG;
            row_border_reg <= '0;
        end
        else if (fire)
        begin
            col_reg        <= col_next;
            first_row_reg  <= first_row_next;
            diag_reg       <= diag_next;
            left_reg       <= left_next;
            ldir_reg       <= ldir_next;
            row_border_reg <= row_border_next;
        end
    end

endmodule

// File: rtl/alignment_score_matrix_fill_unit.sv
// Top level of the alignment score matrix fill unit: stream ports, configuration and pipeline.
// An accepted word is registered in the input stage, then its cell result is registered in
// the output register and shown on m_tvalid; an output stall holds it in the input stage.
// Throughput: one cell word per cycle unless the output stalls; the previous row is read
// from the line store at acceptance, and the left neighbour is the previous cell's result.
// Reset clears the row state and the configuration but sets cols_in_use to 1024; the line
// store is not cleared, and a matrix should begin with a word whose tuser is set.
`timescale 1ns / 1ps

module alignment_score_matrix_fill_unit
    import asmf_pkg::*;
#(
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int SCORE_BITS = SCORE_BITS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [SUB_W-1:0]                       s_tdata,   // sub_score
    input  logic                                   s_tuser,   // new_alignment
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((SCORE_BITS+2+7)/8)*8-1:0]      m_tdata,   // cell_score, came_from
    output logic                                   m_tlast,   // row_end
    input  logic                                   cfg_we,
    input  logic [CFG_IDX_W-1:0]                   cfg_index,
    input  logic [CFG_DATA_W-1:0]                  cfg_data
);

    localparam int SW     = SCORE_BITS;
    localparam int OUT_W  = ((SCORE_BITS + 2 + 7) / 8) * 8;
    localparam int IDX_W  = $clog2(MAX_COLS);
    localparam int PRODW  = PEN_W + IDX_W + 1;
    localparam int CW     = ((PRODW > SW) ? PRODW : SW) + 1;

    cfg_t cfg_reg;

    logic                  s1_valid_reg;
    logic signed [SUB_W-1:0] s1_sub_reg;
    logic                  s1_restart_reg;
    logic                  s1_fire, in_fire;

    logic                  out_valid_reg;
    logic signed [SW-1:0]  out_score_reg;
    dir_t                  out_dir_reg;
    logic                  out_last_reg;

    logic signed [SW-1:0]  border_pre_reg, border_pre_next;
    logic [IDX_W-1:0]      col_pred;
    logic [PRODW-1:0]      prod;
    logic [CW-1:0]         prod_c;

    logic [SW+1:0]         line_rdata;
    logic signed [SW-1:0]  pe_best;
    dir_t                  pe_dec;
    logic                  pe_last;
    logic [IDX_W-1:0]      pe_col, pe_col_after;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gap_open    <= '0;
            cfg_reg.gap_extend  <= '0;
            cfg_reg.global_mode <= 1'b0;
            cfg_reg.cols_in_use <= COLS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GAP_OPEN:    cfg_reg.gap_open    <= cfg_data[PEN_W-1:0];
                REG_GAP_EXTEND:  cfg_reg.gap_extend  <= cfg_data[PEN_W-1:0];
                REG_GLOBAL_MODE: cfg_reg.global_mode <= cfg_data[0];
                REG_COLS_IN_USE: cfg_reg.cols_in_use <= cfg_data[COLS_CFG_W-1:0];
                default:         cfg_reg.gap_open    <= cfg_reg.gap_open;
            endcase
        end
    end

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign in_fire  = s_tvalid && s_tready;

    // Column of the incoming word, known before the word in the input stage has finished.
    assign col_pred = s_tuser ? '0 : pe_col_after;

    // Global-mode top border for that column: the negated product, saturated.
    always_comb
    begin
        prod   = PRODW'(cfg_reg.gap_extend) * (PRODW'(col_pred) + PRODW'(1));
        prod_c = CW'(prod);
        if (prod_c > (CW'(1) << (SW - 1)))
        begin
            border_pre_next = {1'b1, {(SW-1){1'b0}}};
        end
        else
        begin
            border_pre_next = SW'(~prod_c + CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_sub_reg     <= signed'(s_tdata);
            s1_restart_reg <= s_tuser;
            border_pre_reg <= border_pre_next;
        end
    end

    asmf_line_store #(
        .DEPTH (MAX_COLS),
        .WIDTH (SW + 2)
    ) u_line_store (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (pe_col),
        .wdata ({pe_dec, pe_best}),
        .re    (in_fire),
        .raddr (col_pred),
        .rdata (line_rdata)
    );

    asmf_cell_pe #(
        .MAX_COLS   (MAX_COLS),
        .SCORE_BITS (SCORE_BITS)
    ) u_cell_pe (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .fire         (s1_fire),
        .restart      (s1_restart_reg),
        .sub_score    (s1_sub_reg),
        .up_score_mem (signed'(line_rdata[SW-1:0])),
        .up_dir_mem   (dir_t'(line_rdata[SW+1:SW])),
        .border_pre   (border_pre_reg),
        .best         (pe_best),
        .dec          (pe_dec),
        .last         (pe_last),
        .col          (pe_col),
        .col_after    (pe_col_after)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_score_reg <= pe_best;
            out_dir_reg   <= pe_dec;
            out_last_reg  <= pe_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_dir_reg, out_score_reg});
    assign m_tlast  = out_last_reg;

    a_stall_holds_cell: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |-> !s1_fire)
        else $error("cell advanced while the output word was stalled");

    a_cell_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("finished cell did not reach the output register");

    a_row_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && pe_last |=> pe_col == '0)
        else $error("column did not return to zero after the last cell of a row");

    a_local_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !cfg_reg.global_mode |-> !out_score_reg[SW-1])
        else $error("negative score in local mode");

endmodule
